/* rtl/ipdfp_pkg.sv */
// ----------------------------------------------------------------------------
// IPD frame parser package
// Phase encoding, character constants and limits shared by the parser.
// ----------------------------------------------------------------------------
package ipdfp_pkg;

    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PREFIX_LEN  = 5;
    localparam int unsigned PCNT_W      = 3;

    localparam logic [LEN_W-1:0] ACC_SAT       = 7'd127;
    localparam logic [LEN_W-1:0] LIMIT_CAP     = 7'd126;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_L = 7'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] CFG_RESET     = 7'd50;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [PCNT_W-1:0] PCNT_LAST = 3'd4;

    localparam logic [BYTE_W-1:0] IPD_PREFIX [PREFIX_LEN] = '{
        8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C
    };

    // Register indexes of the configuration port.
    localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;

    localparam logic STATUS_PAYLOAD = 1'b0;
    localparam logic STATUS_ERROR   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

endpackage

/* rtl/at_ipd_frame_parser.sv */
// ----------------------------------------------------------------------------
// IPD frame parser
// Deframes '+IPD,n:payload' notifications from a received modem byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per word on the slave side, one word every clock
// cycle while the result register is free or being emptied; the state update
// is a single pass of logic between the parser state and the result register,
// so a word's result appears in the cycle after it is accepted. Bytes outside a
// notification and the header bytes give no result; each payload byte gives
// one word, and a bad length (zero, a non-digit or above the limit) gives one
// error word when the colon arrives.
// ----------------------------------------------------------------------------
module at_ipd_frame_parser
    import ipdfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [7:0] payload_byte, [8] is_first, [15:9] payload_length
    output logic        o_m_tlast,    // is_last
    output logic        o_m_tuser,    // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_phase             r_phase, n_phase;
    logic [PCNT_W-1:0]  r_pcnt, n_pcnt;
    logic               r_pok, n_pok;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic               r_derr, n_derr;
    logic [LEN_W-1:0]   r_dcnt, n_dcnt;
    logic [LEN_W-1:0]   r_max_len;

    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic               r_out_last;
    logic               r_out_status;

    logic               n_res_valid;
    logic               n_res_status;
    logic [BYTE_W-1:0]  n_res_byte;
    logic               n_res_first;
    logic               n_res_last;
    logic [LEN_W-1:0]   n_res_len;

    logic               accept;
    logic               cfg_write;
    logic [LEN_W-1:0]   limit;
    logic [10:0]        acc_sum;
    logic [LEN_W-1:0]   dcnt_inc;
    logic [BYTE_W-1:0]  rx;
    logic               is_digit;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == REG_MAX_PAYLOAD_LEN) ? {25'd0, r_max_len} : 32'd0;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign rx         = i_s_tdata;

    assign limit    = (r_max_len > MAX_PAYLOAD_L) ? MAX_PAYLOAD_L :
                      ((r_max_len > LIMIT_CAP) ? LIMIT_CAP : r_max_len);
    assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
    assign acc_sum  = 11'(r_acc) * 11'd10 + 11'(rx - CH_ZERO);
    assign dcnt_inc = r_dcnt + 7'd1;

    always_comb begin
        n_phase      = r_phase;
        n_pcnt       = r_pcnt;
        n_pok        = r_pok;
        n_acc        = r_acc;
        n_derr       = r_derr;
        n_dcnt       = r_dcnt;
        n_res_valid  = 1'b0;
        n_res_status = STATUS_PAYLOAD;
        n_res_byte   = '0;
        n_res_first  = 1'b0;
        n_res_last   = 1'b0;
        n_res_len    = '0;
        case (r_phase)
            PH_LEN: begin
                if (rx == CH_COLON) begin
                    if (r_derr || (r_acc == '0) || (r_acc > limit)) begin
                        n_res_valid  = 1'b1;
                        n_res_status = STATUS_ERROR;
                        n_phase      = PH_IDLE;
                        n_pcnt       = '0;
                        n_pok        = 1'b1;
                        n_acc        = '0;
                        n_derr       = 1'b0;
                        n_dcnt       = '0;
                    end else begin
                        n_phase = PH_DATA;
                        n_dcnt  = '0;
                    end
                end else if (is_digit) begin
                    n_acc = (acc_sum > 11'(ACC_SAT)) ? ACC_SAT : acc_sum[LEN_W-1:0];
                end else begin
                    n_derr = 1'b1;
                end
            end
            PH_DATA: begin
                n_res_valid = 1'b1;
                n_res_byte  = rx;
                n_res_first = (r_dcnt == '0);
                n_res_last  = (dcnt_inc >= r_acc);
                n_res_len   = r_acc;
                n_dcnt      = dcnt_inc;
                if (dcnt_inc >= r_acc) begin
                    n_phase = PH_IDLE;
                    n_pcnt  = '0;
                    n_pok   = 1'b1;
                    n_acc   = '0;
                    n_derr  = 1'b0;
                    n_dcnt  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (r_pcnt == '0) begin
                    if (rx == CH_PLUS) begin
                        n_pcnt = 3'd1;
                        n_pok  = 1'b1;
                    end
                end else if (r_pcnt > PCNT_LAST) begin
                    n_pcnt = '0;
                    n_pok  = 1'b1;
                end else begin
                    if (r_pcnt == PCNT_LAST) begin
                        if (r_pok && (rx == IPD_PREFIX[r_pcnt])) begin
                            n_phase = PH_LEN;
                            n_acc   = '0;
                            n_derr  = 1'b0;
                        end
                        n_pcnt = '0;
                        n_pok  = 1'b1;
                    end else begin
                        n_pok  = r_pok && (rx == IPD_PREFIX[r_pcnt]);
                        n_pcnt = r_pcnt + 3'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pcnt    <= '0;
            r_pok     <= 1'b1;
            r_acc     <= '0;
            r_derr    <= 1'b0;
            r_dcnt    <= '0;
            r_max_len <= CFG_RESET;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pcnt  <= n_pcnt;
                r_pok   <= n_pok;
                r_acc   <= n_acc;
                r_derr  <= n_derr;
                r_dcnt  <= n_dcnt;
            end
            if (cfg_write && (paddr[2] == REG_MAX_PAYLOAD_LEN)) begin
                r_max_len <= pwdata[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_res_valid) begin
            r_out_data   <= {n_res_len, n_res_first, n_res_byte};
            r_out_last   <= n_res_last;
            r_out_status <= n_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_status;

    a_error_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_ERROR) |-> (r_out_data == 16'd0 && !r_out_last))
        else $error("error word carries payload fields");

    a_payload_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_PAYLOAD)
            |-> (r_out_data[15:9] != '0 && r_out_data[15:9] <= MAX_PAYLOAD_L))
        else $error("payload word with length outside the limit");

    a_data_phase_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_acc != '0 && r_dcnt < r_acc && r_acc <= MAX_PAYLOAD_L))
        else $error("data phase count overruns announced length");

    a_prefix_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_pcnt == '0 && r_pok))
        else $error("prefix tracking not cleared outside idle phase");

endmodule

/* bench/tb_at_ipd_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPD frame parser testbench
// Feeds received bytes into the parser as '+IPD,n:payload' notifications.
// Most of them are well formed. The rest have a broken prefix, a bad length
// or are line noise. A behavioural parser predicts every payload and error
// word, and each word that leaves the block is compared with it field by
// field. The length limit is changed between phases, and both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_at_ipd_frame_parser;
    import ipdfp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BYTES  = 80;
    localparam int LONG_HOLD    = 300;
    localparam logic [2:0] MAX_LEN_ADDR = 3'(4 * int'(REG_MAX_PAYLOAD_LEN));

    typedef struct packed {
        logic              status;
        logic [7:0]        payload_byte;
        logic              is_first;
        logic              is_last;
        logic [LEN_W-1:0]  payload_length;
    } t_ipd_word;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE
    } t_ready_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic [31:0] prdata;
    logic        pready;

    at_ipd_frame_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Behavioural parser state.
    t_phase           parse_phase = PH_IDLE;
    logic [PCNT_W-1:0] prefix_seen = '0;
    logic             prefix_good = 1'b1;
    logic [LEN_W-1:0] length_sum = '0;
    logic             bad_digit = 1'b0;
    logic [LEN_W-1:0] bytes_out = '0;
    logic [LEN_W-1:0] max_len_reg = CFG_RESET;

    logic [7:0] rx_bytes_q[$];
    t_ipd_word  deframed_q[$];

    int mismatches = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int error_words = 0;
    int settings_used = 1;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

    function automatic void parser_to_idle();
        parse_phase = PH_IDLE;
        prefix_seen = '0;
        prefix_good = 1'b1;
        length_sum  = '0;
        bad_digit   = 1'b0;
        bytes_out   = '0;
    endfunction

    function automatic logic [LEN_W-1:0] length_limit();
        logic [LEN_W-1:0] lim;
        lim = max_len_reg;
        if (lim > MAX_PAYLOAD_L) lim = MAX_PAYLOAD_L;
        if (lim > LIMIT_CAP) lim = LIMIT_CAP;
        return lim;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_ipd_word   w;
        int unsigned acc;
        logic        first_b;
        w = '0;
        case (parse_phase)
            PH_LEN: begin
                if (b == CH_COLON) begin
                    if (bad_digit || length_sum == '0 || length_sum > length_limit()) begin
                        w.status = STATUS_ERROR;
                        deframed_q.push_back(w);
                        parser_to_idle();
                    end else begin
                        parse_phase = PH_DATA;
                        bytes_out   = '0;
                    end
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    acc = int'(length_sum) * 10 + int'(b - CH_ZERO);
                    length_sum = (acc > int'(ACC_SAT)) ? ACC_SAT : LEN_W'(acc);
                end else begin
                    bad_digit = 1'b1;
                end
            end
            PH_DATA: begin
                first_b   = (bytes_out == '0);
                bytes_out = bytes_out + 1'b1;
                w.status         = STATUS_PAYLOAD;
                w.payload_byte   = b;
                w.is_first       = first_b;
                w.is_last        = (bytes_out >= length_sum);
                w.payload_length = length_sum;
                deframed_q.push_back(w);
                if (w.is_last) parser_to_idle();
            end
            default: begin
                parse_phase = PH_IDLE;
                if (prefix_seen == '0) begin
                    if (b == CH_PLUS) begin
                        prefix_seen = 3'd1;
                        prefix_good = 1'b1;
                    end
                end else if (prefix_seen > PCNT_LAST) begin
                    prefix_seen = '0;
                    prefix_good = 1'b1;
                end else begin
                    if (b != IPD_PREFIX[prefix_seen]) prefix_good = 1'b0;
                    if (prefix_seen == PCNT_LAST) begin
                        if (prefix_good) begin
                            parse_phase = PH_LEN;
                            length_sum  = '0;
                            bad_digit   = 1'b0;
                        end
                        prefix_seen = '0;
                        prefix_good = 1'b1;
                    end else begin
                        prefix_seen = prefix_seen + 1'b1;
                    end
                end
            end
        endcase
    endtask

    // Sender: bursts of words separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (rx_bytes_q.size() > 0) begin
                    s_tdata  <= rx_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: stalls on a pattern that is drawn anew at random for each segment,
    // with up to two long hold-offs to back the parser up into its input.
    t_ready_mode ready_mode = READY_ALWAYS;
    int seg_left = 0;
    int hold_left = 0;
    int long_holds = 0;

    always @(posedge i_clk) begin
        t_ipd_word want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (deframed_q.size() == 0) begin
                    $error("result word with nothing predicted: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = deframed_q.pop_front();
                    report_field("status", want.status, m_tuser);
                    report_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    report_field("is_first", want.is_first, m_tdata[8]);
                    report_field("is_last", want.is_last, m_tlast);
                    report_field("payload_length", want.payload_length, m_tdata[15:9]);
                end
                results_seen++;
                if (m_tuser == STATUS_ERROR) error_words++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_holds < 2 && results_seen >= 20 + 80 * long_holds &&
                         rx_bytes_q.size() >= 40) begin
                hold_left = LONG_HOLD - 1;
                long_holds++;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    ready_mode = t_ready_mode'($urandom_range(0, 2));
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (ready_mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    default:      m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            rx_bytes_q.push_back(s[i]);
            bytes_queued++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_random_frame();
        int               kind;
        int               lim;
        int               n;
        string            digits;
        logic [7:0]       hdr[PREFIX_LEN];
        logic [7:0]       c;
        int               pos;
        lim  = int'(length_limit());
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            if (lim == 0) begin
                n = $urandom_range(1, 8);
            end else if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, lim);
            end else begin
                n = $urandom_range(1, (lim < 8) ? lim : 8);
            end
            digits = $sformatf("%0d", n);
            if ($urandom_range(0, 9) == 0) digits = {"0", digits};
            push_text({"+IPD,", digits, ":"});
            repeat (n) push_byte(8'($urandom_range(0, 255)));
        end else if (kind < 68) begin
            case ($urandom_range(0, 2))
                0:       push_text("+IPD,:");
                1:       push_text("+IPD,0:");
                default: push_text("+IPD,000:");
            endcase
        end else if (kind < 78) begin
            if ($urandom_range(0, 3) == 0) begin
                digits = "99999";
            end else begin
                digits = $sformatf("%0d", $urandom_range(lim + 1, 130));
            end
            push_text({"+IPD,", digits, ":"});
            repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
        end else if (kind < 84) begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COLON);
            push_text({"+IPD,", $sformatf("%0d", $urandom_range(0, 9))});
            push_byte(c);
            push_text({$sformatf("%0d", $urandom_range(1, 9)), ":"});
        end else if (kind < 90) begin
            hdr = IPD_PREFIX;
            pos = $urandom_range(1, PREFIX_LEN - 1);
            if ($urandom_range(0, 2) == 0) begin
                hdr[pos] = CH_PLUS;
            end else begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (c == IPD_PREFIX[pos]);
                hdr[pos] = c;
            end
            foreach (hdr[i]) push_byte(hdr[i]);
        end else begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_random_phase(input int n_bytes);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) queue_random_frame();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_bytes_q.size() != 0 || s_tvalid || deframed_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_len(input int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_len_reg = LEN_W'(value);
        settings_used++;
    endtask

    initial begin
        int unsigned settings[5];
        settings = '{64, 1, 127, 0, 0};
        settings[4] = $urandom_range(2, 63);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short frame carrying the byte extremes, an empty length, a broken
        // prefix with a second plus inside it, and a letter in the length.
        push_text("+IPD,2:");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("+IPD,:");
        push_text("+I+D,");
        push_text("+IPD,1a:");
        queue_random_phase(PHASE_BYTES);
        wait_drained();

        foreach (settings[i]) begin
            write_max_len(settings[i]);
            queue_random_phase(PHASE_BYTES);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (deframed_q.size() != 0) begin
            $error("%0d predicted words never arrived", deframed_q.size());
            mismatches++;
        end
        $display("Run covered %0d received bytes under %0d length limits.",
                 bytes_sent, settings_used);
        $display("Checked %0d output words, %0d of them length errors.",
                 results_seen, error_words);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
